FILE: rtl/core/sorted_unique_key_table_top_assert.svh
// Assertion macros for the sorted unique key table.
// Used by the top level only; no other dependencies.
`ifndef SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SUKT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sukt assertion failed");

// next-cycle implication
`define SUKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sukt assertion failed");

`endif

FILE: rtl/core/sukt_pkg.sv
// Shared types and constants for the sorted unique key table.
// No dependencies.
package sukt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int KEY_W       = 32;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic apply;
        logic list_start;
        logic list_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic list_last;
    } t_stat;

endpackage

FILE: rtl/core/sukt_ctrl.sv
// Request sequencer for the sorted unique key table.
// Depends on sukt_pkg (command and status structs, action codes).
module sukt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sukt_pkg::ACTION_W-1:0] i_action,
    input  sukt_pkg::t_stat               i_stat,
    output sukt_pkg::t_cmd                o_cmd,
    output logic                          o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_LIST
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (sukt_pkg::t_action'(i_action) == sukt_pkg::ACT_LIST) begin
                        o_cmd.list_start = 1'b1;
                        n_state          = S_LIST;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_IDLE;
            end
            S_LIST: begin
                o_cmd.list_step = 1'b1;
                if (i_stat.list_last) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/sukt_dp.sv
// Datapath: row of compare-and-shift key cells, entry count, list index, result registers.
// Depends on sukt_pkg (types, field widths, status codes).
module sukt_dp #(
    parameter int TABLE_DEPTH = sukt_pkg::TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sukt_pkg::t_cmd                       i_cmd,
    input  logic [sukt_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [sukt_pkg::KEY_W-1:0]    i_key,
    output sukt_pkg::t_stat                      o_stat,
    output logic                                 o_valid,
    output logic [sukt_pkg::STATUS_W-1:0]        o_status,
    output logic signed [sukt_pkg::KEY_W-1:0]    o_result_key,
    output logic [sukt_pkg::POS_W-1:0]           o_position,
    output logic [sukt_pkg::CNT_W-1:0]           o_entry_count,
    output logic                                 o_last
);

    localparam int KW = sukt_pkg::KEY_W;
    localparam int PW = sukt_pkg::POS_W;
    localparam int NW = sukt_pkg::CNT_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [KW-1:0]   r_cell [TABLE_DEPTH];
    logic [CW-1:0]          r_count;
    logic signed [KW-1:0]   r_key;
    sukt_pkg::t_action      r_action;
    logic [TABLE_DEPTH-1:0] r_lt;
    logic [TABLE_DEPTH-1:0] r_eq;
    logic [IW-1:0]          r_idx;

    logic                   r_valid;
    sukt_pkg::t_status      r_status;
    logic signed [KW-1:0]   r_rkey;
    logic [PW-1:0]          r_pos;
    logic [NW-1:0]          r_cnt;
    logic                   r_last;

    logic [TABLE_DEPTH-1:0] bound;
    logic                   hit;
    logic                   full;
    logic [IW-1:0]          pos_hit;
    logic [IW-1:0]          pos_ins;
    logic [CW-1:0]          lim;
    logic                   list_last;
    logic [CW-1:0]          cnt_inc;
    logic [CW-1:0]          cnt_dec;

    function automatic logic [IW-1:0] encode(input logic [TABLE_DEPTH-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (v[i]) begin
                idx = idx | IW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [PW-1:0] to_pos(input logic [IW-1:0] v);
        logic [IW+PW-1:0] t;
        t = {{PW{1'b0}}, v};
        return t[PW-1:0];
    endfunction

    function automatic logic [NW-1:0] to_cnt(input logic [CW-1:0] v);
        logic [CW+NW-1:0] t;
        t = {{NW{1'b0}}, v};
        return t[NW-1:0];
    endfunction

    // first cell not below the key (thermometer edge of r_lt)
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) begin
                bound[i] = ~r_lt[i];
            end else begin
                bound[i] = r_lt[i-1] & ~r_lt[i];
            end
        end
    end

    assign hit     = |r_eq;
    assign full    = (r_count == CW'(TABLE_DEPTH));
    assign pos_hit = encode(r_eq);
    assign pos_ins = encode(bound);
    assign cnt_inc = r_count + CW'(1);
    assign cnt_dec = r_count - CW'(1);

    assign lim = (32'(r_count) > 32'(sukt_pkg::MAX_RESULTS)) ?
                 CW'(sukt_pkg::MAX_RESULTS) : r_count;
    assign list_last = (r_count == '0) || ((CW'(r_idx) + CW'(1)) == lim);
    assign o_stat.list_last = list_last;

    // key cells and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            unique case (r_action)
                sukt_pkg::ACT_INSERT: begin
                    if (!hit && !full) begin
                        r_count <= cnt_inc;
                    end
                end
                sukt_pkg::ACT_DELETE: begin
                    if (hit) begin
                        r_count <= cnt_dec;
                    end
                end
                sukt_pkg::ACT_SEARCH: begin
                end
                sukt_pkg::ACT_LIST: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!r_lt[i]) begin
                    if (r_action == sukt_pkg::ACT_INSERT && !hit && !full) begin
                        if (bound[i]) begin
                            r_cell[i] <= r_key;
                        end else if (i > 0) begin
                            r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                        end
                    end else if (r_action == sukt_pkg::ACT_DELETE && hit) begin
                        if (i < TABLE_DEPTH - 1) begin
                            r_cell[i] <= r_cell[(i < TABLE_DEPTH - 1) ? i + 1 : i];
                        end
                    end
                end
            end
        end
    end

    // compare stage, registered at request accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key    <= i_key;
            r_action <= sukt_pkg::t_action'(i_action);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_lt[i] <= (CW'(i) < r_count) && (r_cell[i] < i_key);
                r_eq[i] <= (CW'(i) < r_count) && (r_cell[i] == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_start) begin
            r_idx <= '0;
        end else if (i_cmd.list_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.apply || i_cmd.list_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_step) begin
            r_last <= list_last;
            r_cnt  <= to_cnt(r_count);
            if (r_count == '0) begin
                r_status <= sukt_pkg::ST_EMPTY;
                r_rkey   <= '0;
                r_pos    <= '0;
            end else begin
                r_status <= sukt_pkg::ST_OK;
                r_rkey   <= r_cell[r_idx];
                r_pos    <= to_pos(r_idx);
            end
        end else if (i_cmd.apply) begin
            r_last <= 1'b1;
            priority if (r_action == sukt_pkg::ACT_INSERT) begin
                r_rkey <= r_key;
                if (hit) begin
                    r_status <= sukt_pkg::ST_DUP;
                    r_pos    <= to_pos(pos_hit);
                    r_cnt    <= to_cnt(r_count);
                end else if (full) begin
                    r_status <= sukt_pkg::ST_FULL;
                    r_pos    <= '0;
                    r_cnt    <= to_cnt(r_count);
                end else begin
                    r_status <= sukt_pkg::ST_OK;
                    r_pos    <= to_pos(pos_ins);
                    r_cnt    <= to_cnt(cnt_inc);
                end
            end else if (!hit) begin
                r_status <= sukt_pkg::ST_NOT_FOUND;
                r_rkey   <= '0;
                r_pos    <= '0;
                r_cnt    <= to_cnt(r_count);
            end else begin
                r_status <= sukt_pkg::ST_OK;
                r_rkey   <= r_key;
                r_pos    <= to_pos(pos_hit);
                r_cnt    <= (r_action == sukt_pkg::ACT_DELETE) ?
                            to_cnt(cnt_dec) : to_cnt(r_count);
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_result_key  = r_rkey;
    assign o_position    = r_pos;
    assign o_entry_count = r_cnt;
    assign o_last        = r_last;

endmodule

FILE: rtl/core/sorted_unique_key_table_top.sv
// Top level of the sorted unique key table: sequencer plus cell-row datapath.
// Depends on sukt_pkg, sukt_ctrl, sukt_dp and sorted_unique_key_table_top_assert.svh.
//
//  channel   handshake            payload
//  request   start & !busy        i_action, i_key
//  result    o_valid (1 cycle)    o_status, o_result_key, o_position, o_entry_count, o_last
//
// Insert, delete, search: compare of all cells is registered at accept, shift/update and
// result register follow in the next cycle, while busy holds off further requests.
// List: after accept, keys are emitted one per cycle, min(count, 16) of them, or a single
// empty result for an empty table; each list cycle reads one cell through the list index.
// Synchronous reset clears the entry count and the strobe; no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
`include "sorted_unique_key_table_top_assert.svh"

module sorted_unique_key_table_top #(
    parameter int TABLE_DEPTH = sukt_pkg::TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sukt_pkg::ACTION_W-1:0]     i_action,
    input  logic signed [sukt_pkg::KEY_W-1:0] i_key,
    output logic                              o_valid,
    output logic [sukt_pkg::STATUS_W-1:0]     o_status,
    output logic signed [sukt_pkg::KEY_W-1:0] o_result_key,
    output logic [sukt_pkg::POS_W-1:0]        o_position,
    output logic [sukt_pkg::CNT_W-1:0]        o_entry_count,
    output logic                              o_last
);

    sukt_pkg::t_cmd  cmd;
    sukt_pkg::t_stat stat;

    sukt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sukt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_key         (i_key),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_result_key  (o_result_key),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    // empty status only as a single final result with zero count
    `SUKT_ASSERT_NOW(a_empty_single, i_clk, i_rst_n,
        o_valid && (o_status == sukt_pkg::ST_EMPTY),
        o_last && (o_entry_count == '0))
    // a list streams without gaps until its last key
    `SUKT_ASSERT_NEXT(a_list_no_gap, i_clk, i_rst_n, o_valid && !o_last, o_valid)
    // an accepted request always occupies the sequencer
    `SUKT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // an apply cycle always yields a result
    `SUKT_ASSERT_NEXT(a_apply_result, i_clk, i_rst_n, cmd.apply, o_valid && o_last)

endmodule

FILE: tb/sv/sorted_unique_key_table_top_tb.sv
// Self-checking bench for sorted_unique_key_table_top: directed table, then random requests.
// A local sorted-key model predicts all but typed rows; depends on sukt_pkg and top level.
module sorted_unique_key_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sukt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_ROWS     = 28;
    localparam int NUM_SEGMENTS = 10;
    localparam int SEGMENT_LEN  = 40;

    typedef struct packed {
        t_status                   status;
        logic signed [KEY_W-1:0]   rkey;
        logic [POS_W-1:0]          pos;
        logic [CNT_W-1:0]          cnt;
        logic                      last;
    } t_table_result;

    typedef struct {
        t_action                   act;
        logic signed [KEY_W-1:0]   key;
        bit                        typed;
        t_status                   st;
        logic signed [KEY_W-1:0]   rkey;
        int                        pos;
        int                        cnt;
    } t_request_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [ACTION_W-1:0]         i_action;
    logic signed [KEY_W-1:0]     i_key;
    logic                        o_valid;
    logic [STATUS_W-1:0]         o_status;
    logic signed [KEY_W-1:0]     o_result_key;
    logic [POS_W-1:0]            o_position;
    logic [CNT_W-1:0]            o_entry_count;
    logic                        o_last;

    logic signed [KEY_W-1:0]     model_keys [TABLE_DEPTH];
    int                          model_count;
    t_table_result               step_out [MAX_RESULTS];
    int                          step_n;
    t_table_result               pending_results [$];
    t_request_row                directed_rows [NUM_ROWS];
    int                          mismatch_count;
    int                          cycle_count;

    sorted_unique_key_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_result_key  (o_result_key),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_table_result make_result(t_status s, logic signed [KEY_W-1:0] k,
                                                  int pos, int cnt, bit last);
        t_table_result r;
        r.status = s;
        r.rkey   = k;
        r.pos    = POS_W'(pos);
        r.cnt    = CNT_W'(cnt);
        r.last   = last;
        return r;
    endfunction

    task automatic predict_table_op(input t_action act, input logic signed [KEY_W-1:0] k);
        int  p;
        int  lim;
        bit  hit;
        step_n = 1;
        if (act == ACT_LIST) begin
            if (model_count == 0) begin
                step_out[0] = make_result(ST_EMPTY, '0, 0, 0, 1'b1);
            end else begin
                lim = (model_count > MAX_RESULTS) ? MAX_RESULTS : model_count;
                for (int i = 0; i < lim; i++)
                    step_out[i] = make_result(ST_OK, model_keys[i], i, model_count, i == lim - 1);
                step_n = lim;
            end
            return;
        end
        p = 0;
        while (p < model_count && model_keys[p] < k)
            p++;
        hit = (p < model_count) && (model_keys[p] == k);
        if (act == ACT_INSERT) begin
            if (hit) begin
                step_out[0] = make_result(ST_DUP, k, p, model_count, 1'b1);
            end else if (model_count >= TABLE_DEPTH) begin
                step_out[0] = make_result(ST_FULL, k, 0, model_count, 1'b1);
            end else begin
                for (int i = model_count; i > p; i--)
                    model_keys[i] = model_keys[i - 1];
                model_keys[p] = k;
                model_count++;
                step_out[0] = make_result(ST_OK, k, p, model_count, 1'b1);
            end
        end else if (!hit) begin
            step_out[0] = make_result(ST_NOT_FOUND, '0, 0, model_count, 1'b1);
        end else begin
            if (act == ACT_DELETE) begin
                for (int i = p; i + 1 < model_count; i++)
                    model_keys[i] = model_keys[i + 1];
                model_count--;
            end
            step_out[0] = make_result(ST_OK, k, p, model_count, 1'b1);
        end
    endtask

    function automatic int pick_gap(bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && model_count > 0)
            return model_keys[$urandom_range(0, model_count - 1)];
        if (r < 75)
            return $signed($urandom_range(0, 40)) - 20;
        if (r < 79)
            return 32'h7FFF_FFFF;
        if (r < 82)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic t_action pick_action(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ACT_LIST;
        if (r < 30)
            return ACT_SEARCH;
        if (r < (grow ? 78 : 45))
            return ACT_INSERT;
        return ACT_DELETE;
    endfunction

    task automatic issue_request(input t_action act, input logic signed [KEY_W-1:0] k,
                                 input int gap, input bit typed, input t_table_result typed_res);
        start    <= 1'b1;
        i_action <= act;
        i_key    <= k;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_table_op(act, k);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            for (int i = 0; i < step_n; i++)
                pending_results.push_back(step_out[i]);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_table_result exp_res;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: ",
                             "st=%0d key=%0d pos=%0d cnt=%0d last=%0d",
                             $time, o_status, o_result_key, o_position, o_entry_count, o_last);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status || o_result_key !== exp_res.rkey ||
                    o_position !== exp_res.pos || o_entry_count !== exp_res.cnt ||
                    o_last !== exp_res.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp st=%0d key=%0d pos=%0d cnt=%0d last=%0d, ",
                                 "got st=%0d key=%0d pos=%0d cnt=%0d last=%0d",
                                 $time, exp_res.status, exp_res.rkey, exp_res.pos, exp_res.cnt,
                                 exp_res.last, o_status, o_result_key, o_position,
                                 o_entry_count, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_action act;
        start          = 1'b0;
        i_action       = ACT_INSERT;
        i_key          = '0;
        i_rst_n        = 1'b0;
        model_count    = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        // typed rows: empty table, extremes, duplicate, full, miss
        directed_rows = '{
            '{ACT_LIST,   32'sd0,       1'b1, ST_EMPTY,     32'sd0,       0, 0},
            '{ACT_SEARCH, 32'sd5,       1'b1, ST_NOT_FOUND, 32'sd0,       0, 0},
            '{ACT_DELETE, 32'sd5,       1'b1, ST_NOT_FOUND, 32'sd0,       0, 0},
            '{ACT_INSERT, 32'h7FFFFFFF, 1'b1, ST_OK,        32'h7FFFFFFF, 0, 1},
            '{ACT_INSERT, 32'h80000000, 1'b1, ST_OK,        32'h80000000, 0, 2},
            '{ACT_INSERT, 32'sd0,       1'b1, ST_OK,        32'sd0,       1, 3},
            '{ACT_INSERT, 32'sd0,       1'b1, ST_DUP,       32'sd0,       1, 3},
            '{ACT_SEARCH, 32'h7FFFFFFF, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_LIST,   32'hFFFFFFFF, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, -32'sd1,      1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'h55555555, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'hAAAAAAAA, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'sd1,       1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, -32'sd2,      1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'h40000000, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'hC0000000, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'sd7,       1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'h0000FFFF, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'hFFFF0000, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'sd100,     1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, -32'sd100,    1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'h12345678, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_INSERT, 32'sd3,       1'b1, ST_FULL,      32'sd3,       0, 16},
            '{ACT_INSERT, 32'h55555555, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_LIST,   32'sd0,       1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_DELETE, 32'h80000000, 1'b0, ST_OK,        32'sd0,       0, 0},
            '{ACT_SEARCH, 32'h80000000, 1'b1, ST_NOT_FOUND, 32'sd0,       0, 15},
            '{ACT_DELETE, 32'h7FFFFFFF, 1'b0, ST_OK,        32'sd0,       0, 0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].act, directed_rows[i].key, pick_gap(1'b0),
                          directed_rows[i].typed,
                          make_result(directed_rows[i].st, directed_rows[i].rkey,
                                      directed_rows[i].pos, directed_rows[i].cnt, 1'b1));
        wait_for_drain();

        // alternate insert-heavy and delete-heavy segments so the table fills and empties
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            for (int n = 0; n < SEGMENT_LEN; n++) begin
                act = pick_action(seg % 2 == 0);
                issue_request(act, pick_key(), pick_gap(seg % 3 == 2), 1'b0, '0);
            end
            if (seg % 3 == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sukt_pkg.sv
rtl/core/sukt_ctrl.sv
rtl/core/sukt_dp.sv
rtl/core/sorted_unique_key_table_top.sv
tb/sv/sorted_unique_key_table_top_tb.sv
